/* design/apcd_pkg.sv */
`timescale 1ns / 1ps
package apcd_pkg;

  localparam int MAX_AGENTS = 16;
  localparam int AGENT_BITS = $clog2(MAX_AGENTS);
  localparam int CNT_BITS   = AGENT_BITS + 1;
  localparam int COORD_BITS = 10;
  localparam int STEP_BITS  = 16;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_EDGE   = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } coord_t;

  typedef struct packed {
    logic                  valid;
    logic [AGENT_BITS-1:0] a;
    logic [AGENT_BITS-1:0] b;
    coord_t                at;
    coord_t                to;
  } hit_t;

  typedef struct packed {
    logic                  v_hit;
    logic [AGENT_BITS-1:0] v_idx;
    logic                  e_hit;
    logic [AGENT_BITS-1:0] e_idx;
    coord_t                e_to;
  } match_t;

  typedef struct packed {
    logic                  found;
    logic                  kind;
    logic [STEP_BITS-1:0]  step;
    logic [AGENT_BITS-1:0] first_agent;
    logic [AGENT_BITS-1:0] second_agent;
    coord_t                at;
    coord_t                to;
  } result_t;

  typedef struct packed {
    logic [AGENT_BITS-1:0] agent;
    logic                  bank_sel;
    logic                  frame_nz;
  } frame_ctx_t;

  function automatic logic [AGENT_BITS-1:0] lowest_set(input logic [MAX_AGENTS-1:0] v);
    logic [AGENT_BITS-1:0] idx;
    idx = '0;
    for (int i = MAX_AGENTS - 1; i >= 0; i--) begin
      if (v[i]) idx = AGENT_BITS'(i);
    end
    return idx;
  endfunction

endpackage

/* design/apcd_match.sv */
`timescale 1ns / 1ps
module apcd_match (
  input  logic                clk,
  input  logic                wr_en,
  input  apcd_pkg::coord_t    pos,
  input  apcd_pkg::frame_ctx_t ctx,
  output apcd_pkg::match_t    match
);
  import apcd_pkg::*;

  // two banks: current frame in bank[bank_sel], previous frame in the other
  coord_t bank_r [2][MAX_AGENTS];

  coord_t                cur    [MAX_AGENTS];
  coord_t                prev   [MAX_AGENTS];
  coord_t                prev_j;
  logic [MAX_AGENTS-1:0] v_vec;
  logic [MAX_AGENTS-1:0] e_vec;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_r[ctx.bank_sel][ctx.agent] <= pos;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_AGENTS; k++) begin
      cur[k]  = bank_r[ctx.bank_sel][k];
      prev[k] = bank_r[!ctx.bank_sel][k];
    end
  end

  assign prev_j = bank_r[!ctx.bank_sel][ctx.agent];

  always_comb begin
    for (int k = 0; k < MAX_AGENTS; k++) begin
      v_vec[k] = (AGENT_BITS'(k) < ctx.agent) && (cur[k] == pos);
      e_vec[k] = (AGENT_BITS'(k) < ctx.agent) && ctx.frame_nz &&
                 (prev[k] == pos) && (cur[k] == prev_j);
    end
  end

  always_comb begin
    match.v_hit = |v_vec;
    match.v_idx = lowest_set(v_vec);
    match.e_hit = |e_vec;
    match.e_idx = lowest_set(e_vec);
    match.e_to  = prev_j;
  end

endmodule

/* design/apcd_ctrl.sv */
`timescale 1ns / 1ps
module apcd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  apcd_pkg::coord_t              pos,
  input  logic                          final_frame,
  input  logic [apcd_pkg::CNT_BITS-1:0] agent_count,
  input  apcd_pkg::match_t              match,
  output apcd_pkg::frame_ctx_t          ctx,
  output logic                          emit,
  output apcd_pkg::result_t             result
);
  import apcd_pkg::*;

  logic [AGENT_BITS-1:0] agent_r, agent_nxt;
  logic [STEP_BITS-1:0]  frame_r, frame_nxt;
  logic                  bank_sel_r, bank_sel_nxt;
  logic                  reported_r, reported_nxt;
  hit_t                  vhit_r, vhit_nxt;
  hit_t                  ehit_r, ehit_nxt;

  logic [CNT_BITS-1:0] n_eff;
  logic                last;
  hit_t                vhit_upd;
  hit_t                ehit_upd;

  always_comb begin
    if (agent_count < CNT_BITS'(2)) begin
      n_eff = CNT_BITS'(2);
    end else if (agent_count > CNT_BITS'(MAX_AGENTS)) begin
      n_eff = CNT_BITS'(MAX_AGENTS);
    end else begin
      n_eff = agent_count;
    end
  end

  assign last = ({1'b0, agent_r} + CNT_BITS'(1)) >= n_eff;

  always_comb begin
    vhit_upd = vhit_r;
    if (match.v_hit && (!vhit_r.valid || match.v_idx < vhit_r.a)) begin
      vhit_upd.valid = 1'b1;
      vhit_upd.a     = match.v_idx;
      vhit_upd.b     = agent_r;
      vhit_upd.at    = pos;
      vhit_upd.to    = '0;
    end
    ehit_upd = ehit_r;
    if (match.e_hit && (!ehit_r.valid || match.e_idx < ehit_r.a)) begin
      ehit_upd.valid = 1'b1;
      ehit_upd.a     = match.e_idx;
      ehit_upd.b     = agent_r;
      ehit_upd.at    = pos;
      ehit_upd.to    = match.e_to;
    end
  end

  assign emit = last && !reported_r && (ehit_upd.valid || vhit_upd.valid || final_frame);

  always_comb begin
    result = '0;
    if (ehit_upd.valid) begin
      result.found        = 1'b1;
      result.kind         = KIND_EDGE;
      result.step         = frame_r - STEP_BITS'(1);
      result.first_agent  = ehit_upd.a;
      result.second_agent = ehit_upd.b;
      result.at           = ehit_upd.at;
      result.to           = ehit_upd.to;
    end else if (!final_frame && vhit_upd.valid) begin
      result.found        = 1'b1;
      result.kind         = KIND_VERTEX;
      result.step         = frame_r;
      result.first_agent  = vhit_upd.a;
      result.second_agent = vhit_upd.b;
      result.at           = vhit_upd.at;
    end
  end

  always_comb begin
    agent_nxt    = agent_r;
    frame_nxt    = frame_r;
    bank_sel_nxt = bank_sel_r;
    reported_nxt = reported_r;
    vhit_nxt     = vhit_r;
    ehit_nxt     = ehit_r;
    if (fire) begin
      if (!last) begin
        agent_nxt = agent_r + AGENT_BITS'(1);
        vhit_nxt  = vhit_upd;
        ehit_nxt  = ehit_upd;
      end else if (final_frame) begin
        agent_nxt    = '0;
        frame_nxt    = '0;
        reported_nxt = 1'b0;
        vhit_nxt     = '0;
        ehit_nxt     = '0;
      end else begin
        agent_nxt    = '0;
        bank_sel_nxt = !bank_sel_r;
        if (frame_r != '1) frame_nxt = frame_r + STEP_BITS'(1);
        if (emit) reported_nxt = 1'b1;
        vhit_nxt = '0;
        ehit_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agent_r    <= '0;
      frame_r    <= '0;
      bank_sel_r <= 1'b0;
      reported_r <= 1'b0;
      vhit_r     <= '0;
      ehit_r     <= '0;
    end else begin
      agent_r    <= agent_nxt;
      frame_r    <= frame_nxt;
      bank_sel_r <= bank_sel_nxt;
      reported_r <= reported_nxt;
      vhit_r     <= vhit_nxt;
      ehit_r     <= ehit_nxt;
    end
  end

  always_comb begin
    ctx.agent    = agent_r;
    ctx.bank_sel = bank_sel_r;
    ctx.frame_nz = (frame_r != '0);
  end

endmodule

/* design/agent_path_conflict_detector_top.sv */
`timescale 1ns / 1ps
// channel  | ports                                        | transfer when
// ---------+----------------------------------------------+---------------------------
// input    | in_valid in_stall in_pos_x/y in_final_frame  | in_valid & !in_stall
// result   | out_valid out_stall out_found ... out_to_y   | out_valid & !out_stall
// config   | cfg_wr_en cfg_wr_data                        | cfg_wr_en
//
// One position per cycle sustained while in_stall is low; the result register loads when
// the frame's last position fires from the input register, where it can wait on a stall.
// The input register feeds the compare against both frame banks and the hit
// trackers, which load the result register in the same cycle.
// Synchronous active-low reset clears control state and sets agent_count to 2.
// An item that produces a result waits in the input register while the result
// register is full and stalled; other items pass.
module agent_path_conflict_detector_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [apcd_pkg::COORD_BITS-1:0]     in_pos_x,
  input  logic [apcd_pkg::COORD_BITS-1:0]     in_pos_y,
  input  logic                                in_final_frame,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic                                out_kind,
  output logic [apcd_pkg::STEP_BITS-1:0]      out_step,
  output logic [apcd_pkg::AGENT_BITS-1:0]     out_first_agent,
  output logic [apcd_pkg::AGENT_BITS-1:0]     out_second_agent,
  output logic [apcd_pkg::COORD_BITS-1:0]     out_at_x,
  output logic [apcd_pkg::COORD_BITS-1:0]     out_at_y,
  output logic [apcd_pkg::COORD_BITS-1:0]     out_to_x,
  output logic [apcd_pkg::COORD_BITS-1:0]     out_to_y,
  input  logic                                cfg_wr_en,
  input  logic [apcd_pkg::CNT_BITS-1:0]       cfg_wr_data
);
  import apcd_pkg::*;

  logic [CNT_BITS-1:0] agent_count_r;

  logic    s1_valid_r;
  coord_t  s1_pos_r;
  logic    s1_final_r;

  logic    out_valid_r;
  result_t out_r;

  match_t     match;
  frame_ctx_t ctx;
  logic       emit;
  result_t    result;
  logic       slot_free;
  logic       fire;

  assign slot_free = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && (!emit || slot_free);
  assign in_stall  = s1_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agent_count_r <= CNT_BITS'(2);
    end else if (cfg_wr_en) begin
      agent_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pos_r.x <= in_pos_x;
      s1_pos_r.y <= in_pos_y;
      s1_final_r <= in_final_frame;
    end
  end

  apcd_match u_match (
    .clk   (clk),
    .wr_en (fire),
    .pos   (s1_pos_r),
    .ctx   (ctx),
    .match (match)
  );

  apcd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .pos         (s1_pos_r),
    .final_frame (s1_final_r),
    .agent_count (agent_count_r),
    .match       (match),
    .ctx         (ctx),
    .emit        (emit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_r.found;
  assign out_kind         = out_r.kind;
  assign out_step         = out_r.step;
  assign out_first_agent  = out_r.first_agent;
  assign out_second_agent = out_r.second_agent;
  assign out_at_x         = out_r.at.x;
  assign out_at_y         = out_r.at.y;
  assign out_to_x         = out_r.to.x;
  assign out_to_y         = out_r.to.y;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import apcd_pkg::*;

  class conflict_plan_tracker;
    logic [CNT_BITS-1:0]  count_reg;
    coord_t               prev_cells[MAX_AGENTS];
    coord_t               cur_cells[MAX_AGENTS];
    int unsigned          slot;
    logic [STEP_BITS-1:0] frame_no;
    hit_t                 vertex_hit;
    hit_t                 swap_hit;
    bit                   reported;
    result_t              expected_reports[$];
    int unsigned          errors;
    int unsigned          positions;
    int unsigned          plans;
    int unsigned          vertex_cnt;
    int unsigned          swap_cnt;
    int unsigned          clean_cnt;

    function new();
      count_reg = CNT_BITS'(2);
      clear_plan();
    endfunction

    function void clear_plan();
      slot       = 0;
      frame_no   = '0;
      vertex_hit = '0;
      swap_hit   = '0;
      reported   = 1'b0;
    endfunction

    function void note_position(coord_t p, logic fin);
      int unsigned n;
      int unsigned j;
      bit          emit;
      result_t     r;
      n = (count_reg < 2) ? 2 : ((count_reg > MAX_AGENTS) ? MAX_AGENTS : count_reg);
      j = (slot >= MAX_AGENTS) ? MAX_AGENTS - 1 : slot;
      positions++;
      cur_cells[j] = p;
      for (int k = 0; k < j; k++) begin
        if ((!vertex_hit.valid || k < vertex_hit.a) && cur_cells[k] == p) begin
          vertex_hit.valid = 1'b1;
          vertex_hit.a     = AGENT_BITS'(k);
          vertex_hit.b     = AGENT_BITS'(j);
          vertex_hit.at    = p;
          vertex_hit.to    = '0;
        end
        if (frame_no != 0 && (!swap_hit.valid || k < swap_hit.a) &&
            prev_cells[k] == p && cur_cells[k] == prev_cells[j]) begin
          swap_hit.valid = 1'b1;
          swap_hit.a     = AGENT_BITS'(k);
          swap_hit.b     = AGENT_BITS'(j);
          swap_hit.at    = prev_cells[k];
          swap_hit.to    = cur_cells[k];
        end
      end
      if (j + 1 < n) begin
        slot = j + 1;
        return;
      end
      r    = '0;
      emit = 1'b0;
      if (!reported) begin
        if (swap_hit.valid) begin
          r.found        = 1'b1;
          r.kind         = KIND_EDGE;
          r.step         = frame_no - 1'b1;
          r.first_agent  = swap_hit.a;
          r.second_agent = swap_hit.b;
          r.at           = swap_hit.at;
          r.to           = swap_hit.to;
          emit           = 1'b1;
        end else if (!fin && vertex_hit.valid) begin
          r.found        = 1'b1;
          r.kind         = KIND_VERTEX;
          r.step         = frame_no;
          r.first_agent  = vertex_hit.a;
          r.second_agent = vertex_hit.b;
          r.at           = vertex_hit.at;
          emit           = 1'b1;
        end else if (fin) begin
          emit = 1'b1;
        end
        if (emit) begin
          expected_reports.insert(expected_reports.size(), r);
          reported = 1'b1;
        end
      end
      if (fin) begin
        plans++;
        clear_plan();
      end else begin
        prev_cells = cur_cells;
        if (frame_no != '1) frame_no++;
        vertex_hit = '0;
        swap_hit   = '0;
        slot       = 0;
      end
    endfunction

    function int field_diff(string name, longint unsigned want_v, longint unsigned got_v);
      if (want_v == got_v) return 0;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      return 1;
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (got.found) begin
        if (got.kind == KIND_EDGE) swap_cnt++;
        else vertex_cnt++;
      end else begin
        clean_cnt++;
      end
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none actual found=%0b kind=%0b step=%0d",
                 $time, got.found, got.kind, got.step);
        return;
      end
      want = expected_reports.pop_front();
      errors += field_diff("found", want.found, got.found);
      errors += field_diff("kind", want.kind, got.kind);
      errors += field_diff("step", want.step, got.step);
      errors += field_diff("first_agent", want.first_agent, got.first_agent);
      errors += field_diff("second_agent", want.second_agent, got.second_agent);
      errors += field_diff("at_x", want.at.x, got.at.x);
      errors += field_diff("at_y", want.at.y, got.at.y);
      errors += field_diff("to_x", want.to.x, got.to.x);
      errors += field_diff("to_y", want.to.y, got.to.y);
    endfunction
  endclass

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [COORD_BITS-1:0] in_pos_x       = '0;
  logic [COORD_BITS-1:0] in_pos_y       = '0;
  logic                  in_final_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic                  out_found;
  logic                  out_kind;
  logic [STEP_BITS-1:0]  out_step;
  logic [AGENT_BITS-1:0] out_first_agent;
  logic [AGENT_BITS-1:0] out_second_agent;
  logic [COORD_BITS-1:0] out_at_x;
  logic [COORD_BITS-1:0] out_at_y;
  logic [COORD_BITS-1:0] out_to_x;
  logic [COORD_BITS-1:0] out_to_y;
  logic                  cfg_wr_en      = 1'b0;
  logic [CNT_BITS-1:0]   cfg_wr_data    = '0;

  result_t               observed;
  bit                    quiet          = 1'b0;
  int unsigned           random_items   = 0;
  int unsigned           random_plans   = 0;
  conflict_plan_tracker  tracker;

  agent_path_conflict_detector_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_final_frame   (in_final_frame),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_kind         (out_kind),
    .out_step         (out_step),
    .out_first_agent  (out_first_agent),
    .out_second_agent (out_second_agent),
    .out_at_x         (out_at_x),
    .out_at_y         (out_at_y),
    .out_to_x         (out_to_x),
    .out_to_y         (out_to_y),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  assign observed = {out_found, out_kind, out_step, out_first_agent, out_second_agent,
                     out_at_x, out_at_y, out_to_x, out_to_y};

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 33);
  end

  // transfers are sampled on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.note_position(coord_t'({in_pos_x, in_pos_y}), in_final_frame);
      if (out_valid && !out_stall) tracker.check_report(observed);
    end
  end

  task automatic send_position(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                               input logic fin);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_final_frame <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_agent_count(input logic [CNT_BITS-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.count_reg = v;
  endtask

  task automatic run_plan(input int unsigned n, input bit broken);
    coord_t      cells[MAX_AGENTS];
    coord_t      base;
    coord_t      held;
    int unsigned frames;
    int unsigned spread;
    int unsigned a;
    int unsigned b;
    logic        fin;
    frames = ($urandom_range(9) == 0) ? $urandom_range(6, (n > 8) ? 8 : 16)
                                       : $urandom_range(1, 4);
    case ($urandom_range(3))
      0: spread = 1;
      1: spread = 3;
      2: spread = 15;
      default: spread = 1023;
    endcase
    base.x = COORD_BITS'($urandom_range(1023));
    base.y = COORD_BITS'($urandom_range(1023));
    for (int f = 0; f < frames; f++) begin
      for (int i = 0; i < n; i++) begin
        if (f == 0 || $urandom_range(3) == 0) begin
          cells[i].x = base.x + COORD_BITS'($urandom_range(spread));
          cells[i].y = base.y + COORD_BITS'($urandom_range(spread));
        end
      end
      if (f > 0 && $urandom_range(2) == 0) begin
        a        = $urandom_range(n - 1);
        b        = $urandom_range(n - 1);
        held     = cells[a];
        cells[a] = cells[b];
        cells[b] = held;
      end
      for (int i = 0; i < n; i++) begin
        if (i == n - 1) fin = (f == frames - 1) || (broken && $urandom_range(3) == 0);
        else fin = 1'($urandom_range(1));
        send_position(cells[i].x, cells[i].y, fin);
        random_items++;
      end
    end
  endtask

  initial begin
    int unsigned         phase;
    int unsigned         cnt;
    int unsigned         n;
    logic [CNT_BITS-1:0] cfg_pick[8];
    cfg_pick = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd3, 5'd2, 5'd5, 5'd9};
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset count of 2: swap at frame 0 with field extremes, then a one-frame plan
    send_position(10'd0, 10'd0, 1'b1);
    send_position(10'd1023, 10'd1023, 1'b0);
    send_position(10'd1023, 10'd1023, 1'b0);
    send_position(10'd0, 10'd0, 1'b1);
    send_position(10'd5, 10'd5, 1'b0);
    send_position(10'd5, 10'd5, 1'b1);

    // lowest pair wins over the earlier-found higher pair
    drain_reports();
    set_agent_count(5'd4);
    send_position(10'd7, 10'd7, 1'b0);
    send_position(10'd8, 10'd8, 1'b0);
    send_position(10'd8, 10'd8, 1'b0);
    send_position(10'd7, 10'd7, 1'b0);
    repeat (3) send_position(10'd0, 10'd0, 1'b1);
    send_position(10'd1, 10'd0, 1'b1);

    // swap and vertex in the same frame: the swap is reported
    drain_reports();
    set_agent_count(5'd3);
    send_position(10'd1, 10'd0, 1'b0);
    send_position(10'd2, 10'd0, 1'b0);
    send_position(10'd5, 10'd5, 1'b0);
    send_position(10'd2, 10'd0, 1'b0);
    send_position(10'd1, 10'd0, 1'b0);
    send_position(10'd2, 10'd0, 1'b0);
    send_position(10'd0, 10'd0, 1'b0);
    send_position(10'd0, 10'd1, 1'b0);
    send_position(10'd0, 10'd2, 1'b1);

    // count lowered in the middle of a frame
    drain_reports();
    set_agent_count(5'd4);
    send_position(10'd10, 10'd10, 1'b0);
    send_position(10'd11, 10'd11, 1'b0);
    drain_reports();
    set_agent_count(5'd2);
    send_position(10'd10, 10'd10, 1'b0);
    send_position(10'd0, 10'd0, 1'b0);
    send_position(10'd1, 10'd1, 1'b1);

    // one phase runs with no idling on either side
    phase = 0;
    while (random_items < 620) begin
      drain_reports();
      cnt = (phase < 8) ? cfg_pick[phase] : $urandom_range(31);
      set_agent_count(CNT_BITS'(cnt));
      n = (cnt < 2) ? 2 : ((cnt > MAX_AGENTS) ? MAX_AGENTS : cnt);
      quiet = (phase == 2);
      repeat ($urandom_range(2, 4)) begin
        if (random_items < 620) begin
          run_plan(n, $urandom_range(7) == 0);
          random_plans++;
        end
      end
      phase++;
    end
    drain_reports();
    quiet = 1'b0;

    $display("covered %0d positions in %0d plans (%0d random) over %0d count settings",
             tracker.positions, tracker.plans, random_plans, phase + 4);
    $display("reports seen: %0d vertex, %0d swap, %0d conflict-free", tracker.vertex_cnt,
             tracker.swap_cnt, tracker.clean_cnt);
    if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
design/apcd_pkg.sv
design/apcd_match.sv
design/apcd_ctrl.sv
design/agent_path_conflict_detector_top.sv
verif/testbench.sv
